// ===== rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, codes and helpers for the max stack engine and its cells.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned MSE_DEPTH_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_READ_TOP = 3'd2,
        OP_READ_MAX = 3'd3,
        OP_POP_MAX  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_PUSH,
        CH_POP,
        CH_REMOVE
    } t_chain_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] push_value;
    } t_cmd_beat;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic        [1:0]  status;
    } t_result_beat;

    // One stack entry together with the largest value at or below it and a
    // flag telling whether this entry is that largest value.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] max_value;
        logic               mine;
    } t_cell_data;

    // Combines an entry with the summary of the entries below it. Ties go to
    // the upper entry, so the topmost occurrence of the maximum is kept.
    function automatic t_cell_data f_merge(logic signed [31:0] value,
                                           t_cell_data below,
                                           logic below_valid);
        t_cell_data res;
        res.value     = value;
        res.mine      = !below_valid || (value >= below.max_value);
        res.max_value = res.mine ? value : below.max_value;
        return res;
    endfunction

endpackage

// ===== rtl/mse_cell.sv =====
// ----------------------------------------------------------------------------
// mse_cell
// One stack slot: holds an entry and its running maximum, shifts with its
// neighbors and recomputes its maximum during the repair wave.
// ----------------------------------------------------------------------------
module mse_cell #(
    parameter int unsigned STACK_DEPTH = mse_pkg::MSE_DEPTH_DEFAULT,
    parameter int unsigned IDX         = 0,
    localparam int unsigned COUNT_W    = $clog2(STACK_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mse_pkg::t_chain_op   i_op,
    input  logic [COUNT_W-1:0]   i_count,
    input  mse_pkg::t_cell_data  i_above,
    input  mse_pkg::t_cell_data  i_below,
    input  logic                 i_below_dirty,
    input  logic                 i_found_above,
    output logic                 o_found_below,
    output mse_pkg::t_cell_data  o_cell,
    output logic                 o_dirty
);
    import mse_pkg::*;

    t_cell_data r_cell, n_cell;
    logic       r_dirty, n_dirty;
    logic       w_occ;
    logic       w_last;

    assign w_occ         = i_count > COUNT_W'(IDX);
    assign w_last        = i_count == COUNT_W'(IDX + 1);
    assign o_found_below = i_found_above | (r_cell.mine & w_occ);
    assign o_cell        = r_cell;
    assign o_dirty       = r_dirty;

    always_comb begin
        n_cell  = r_cell;
        n_dirty = r_dirty;
        unique case (i_op)
            CH_PUSH: n_cell = i_above;
            CH_POP:  n_cell = i_below;
            CH_REMOVE: begin
                // At or below the removed entry the chain closes the gap;
                // above it the running maximum has to be rebuilt.
                if (o_found_below) begin
                    n_cell = i_below;
                end else begin
                    n_dirty = 1'b1;
                end
            end
            CH_HOLD: begin
                if (r_dirty && !i_below_dirty) begin
                    n_cell  = f_merge(r_cell.value, i_below, !w_last);
                    n_dirty = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b0;
        end else begin
            r_dirty <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

endmodule

// ===== rtl/max_stack_engine.sv =====
// ----------------------------------------------------------------------------
// max_stack_engine
// Bounded stack of signed words that also reads and removes its maximum.
// ----------------------------------------------------------------------------
// Handshake: a command beat is accepted while busy is low; the result beat is
//   registered from the execution state and then strobed.
// Flow: a new beat is accepted only once the last one is done; pop maximum
//   holds busy while the repair wave rebuilds the entries above the removed one.
// Reset: synchronous, clears the entry count, the wave and the handshake;
//   entry contents stay as they are. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module max_stack_engine #(
    parameter int unsigned STACK_DEPTH = mse_pkg::MSE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  mse_pkg::t_cmd_beat    i_cmd,
    output logic                  busy,
    output logic                  o_result_strobe,
    output mse_pkg::t_result_beat o_result
);
    import mse_pkg::*;

    localparam int unsigned COUNT_W = $clog2(STACK_DEPTH + 1);

    // Cell 0 is the top of the stack and the last live cell is the bottom.
    // Every cell keeps the largest value found at or below it, so the stack's
    // maximum sits in cell 0 whenever no repair wave runs. Push and pop shift
    // the whole row by one place, which leaves those summaries intact.

    t_state             r_state, n_state;
    logic               w_exec;
    logic               w_accept;
    t_cmd_beat          r_cmd;
    logic [COUNT_W-1:0] r_count, n_count;
    t_chain_op          w_chain_op;
    t_result_beat       r_result, n_result;
    logic               r_strobe;
    logic               w_full;
    logic               w_empty;
    t_cell_data         w_push_cell;

    t_cell_data         w_cell  [STACK_DEPTH];
    logic               w_dirty [STACK_DEPTH];
    logic               w_found [STACK_DEPTH+1];

    assign w_accept = start && !busy;

    // Next state of the command sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the command sequencer. The block also stays busy while a
    // repair wave runs, and cell 0 is always the last cell the wave reaches.
    always_comb begin
        w_exec = 1'b0;
        unique case (r_state)
            ST_IDLE: w_exec = 1'b0;
            ST_EXEC: w_exec = 1'b1;
            default: w_exec = 1'b0;
        endcase
    end

    assign busy = w_exec || w_dirty[0];

    assign w_full  = r_count == COUNT_W'(STACK_DEPTH);
    assign w_empty = r_count == '0;

    // The entry a push places on top, merged with the old top's summary.
    assign w_push_cell = f_merge(r_cmd.push_value, w_cell[0], !w_empty);

    // Command execution: in the execution state the chain shifts as the
    // command asks and the result is taken from cell 0.
    always_comb begin
        n_count             = r_count;
        w_chain_op          = CH_HOLD;
        n_result.status     = STAT_OK;
        n_result.result_value = '0;
        if (w_exec) begin
            unique case (r_cmd.opcode)
                OP_PUSH: begin
                    if (w_full) begin
                        n_result.status = STAT_FULL;
                    end else begin
                        w_chain_op = CH_PUSH;
                        n_count    = r_count + 1'b1;
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        n_result.status = STAT_EMPTY;
                    end else begin
                        n_result.result_value = w_cell[0].value;
                        w_chain_op            = CH_POP;
                        n_count               = r_count - 1'b1;
                    end
                end
                OP_READ_TOP: begin
                    if (w_empty) begin
                        n_result.status = STAT_EMPTY;
                    end else begin
                        n_result.result_value = w_cell[0].value;
                    end
                end
                OP_READ_MAX: begin
                    if (w_empty) begin
                        n_result.status = STAT_EMPTY;
                    end else begin
                        n_result.result_value = w_cell[0].max_value;
                    end
                end
                OP_POP_MAX: begin
                    // The topmost cell that owns its own summary is the one
                    // removed; cells above it are repaired by the wave.
                    if (w_empty) begin
                        n_result.status = STAT_EMPTY;
                    end else begin
                        n_result.result_value = w_cell[0].max_value;
                        w_chain_op            = CH_REMOVE;
                        n_count               = r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        if (w_exec) begin
            r_result <= n_result;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // The search for the removed entry ripples from the top cell downward.
    assign w_found[0] = 1'b0;

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        t_cell_data w_above;
        t_cell_data w_below;
        logic       w_below_dirty;

        if (gi == 0) begin : g_top
            assign w_above = w_push_cell;
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end

        if (gi == STACK_DEPTH - 1) begin : g_bottom
            assign w_below       = '0;
            assign w_below_dirty = 1'b0;
        end else begin : g_inner
            assign w_below       = w_cell[gi+1];
            assign w_below_dirty = w_dirty[gi+1];
        end

        mse_cell #(
            .STACK_DEPTH (STACK_DEPTH),
            .IDX         (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_chain_op),
            .i_count       (r_count),
            .i_above       (w_above),
            .i_below       (w_below),
            .i_below_dirty (w_below_dirty),
            .i_found_above (w_found[gi]),
            .o_found_below (w_found[gi+1]),
            .o_cell        (w_cell[gi]),
            .o_dirty       (w_dirty[gi])
        );
    end

endmodule

// ===== rtl/mse_checker.sv =====
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the command handshake and result timing.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_result_strobe,
    input mse_pkg::t_result_beat o_result
);
    import mse_pkg::*;

    // An accepted beat holds the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted beat");

    // Every accepted beat yields a strobed result beat.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_strobe)
        else $error("result beat missing after an accepted beat");

    // A result only follows a cycle in which the block is busy.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result beat without a command in flight");

    // Results never come in two consecutive cycles.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result beats too close together");

    // A failed operation returns zero.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_result.status != STAT_OK))
            |-> (o_result.result_value == '0))
        else $error("nonzero value with an error status");

endmodule

bind max_stack_engine mse_checker u_mse_checker (.*);

// ===== verif/tb_max_stack_engine.sv =====
// ----------------------------------------------------------------------------
// tb_max_stack_engine
// Self-checking bench for the max stack engine. Command beats go through the
// start/busy handshake with random idle gaps. A scoreboard keeps its own copy
// of the stack, predicts the result of every accepted command, and compares
// each strobed result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_max_stack_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned RANDOM_CMDS = 750;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the stack that runs each accepted command
    // and queues the result beat it expects.
    // ------------------------------------------------------------------------
    class stack_scoreboard;
        logic signed [31:0] entries [STACK_DEPTH];
        int unsigned        live_count;
        t_result_beat       expected_q[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        full_hits;
        int unsigned        empty_hits;
        int unsigned        deepest_max_pop;

        function new();
            live_count      = 0;
            errors          = 0;
            checked         = 0;
            full_hits       = 0;
            empty_hits      = 0;
            deepest_max_pop = 0;
        endfunction

        // Topmost index holding the largest value; ties go to the upper entry.
        function int unsigned topmost_max_index();
            int unsigned best;
            best = 0;
            for (int unsigned i = 1; i < live_count; i++) begin
                if (entries[i] >= entries[best]) begin
                    best = i;
                end
            end
            return best;
        endfunction

        function void note_cmd(t_cmd_beat cmd);
            t_result_beat exp_beat;
            int unsigned  idx;
            exp_beat.result_value = '0;
            exp_beat.status       = STAT_OK;
            if (cmd.opcode == OP_PUSH) begin
                if (live_count >= STACK_DEPTH) begin
                    exp_beat.status = STAT_FULL;
                    full_hits++;
                end else begin
                    entries[live_count] = cmd.push_value;
                    live_count++;
                end
            end else if (cmd.opcode <= OP_POP_MAX) begin
                if (live_count == 0) begin
                    exp_beat.status = STAT_EMPTY;
                    empty_hits++;
                end else begin
                    case (cmd.opcode)
                        OP_POP: begin
                            live_count--;
                            exp_beat.result_value = entries[live_count];
                        end
                        OP_READ_TOP: begin
                            exp_beat.result_value = entries[live_count - 1];
                        end
                        OP_READ_MAX: begin
                            exp_beat.result_value = entries[topmost_max_index()];
                        end
                        default: begin
                            // Pop maximum: entries above the removed one slide down.
                            idx = topmost_max_index();
                            exp_beat.result_value = entries[idx];
                            if (live_count - 1 - idx > deepest_max_pop) begin
                                deepest_max_pop = live_count - 1 - idx;
                            end
                            for (int unsigned i = idx; i + 1 < live_count; i++) begin
                                entries[i] = entries[i + 1];
                            end
                            live_count--;
                        end
                    endcase
                end
            end
            expected_q.push_back(exp_beat);
        endfunction

        function void check_result(t_result_beat got);
            t_result_beat exp_beat;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat value=%0d status=%0d",
                         $time, got.result_value, got.status);
                errors++;
                return;
            end
            exp_beat = expected_q.pop_front();
            checked++;
            if (got.result_value !== exp_beat.result_value) begin
                $display("%0t: result_value expected %0d actual %0d",
                         $time, exp_beat.result_value, got.result_value);
                errors++;
            end
            if (got.status !== exp_beat.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_beat.status, got.status);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void flag_leftovers();
            if (expected_q.size() != 0) begin
                $display("%0t: %0d expected result beats never arrived",
                         $time, expected_q.size());
                errors += expected_q.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT.
    // ------------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    t_cmd_beat     i_cmd   = '0;
    logic          busy;
    logic          o_result_strobe;
    t_result_beat  o_result;

    stack_scoreboard sb = new();

    int unsigned sent_cmds;
    int unsigned phase_len;
    int unsigned push_pct;
    bit          idle_on;
    int unsigned drain_wait;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    max_stack_engine #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    // The receiver cannot stall, so every strobed beat is taken at the edge
    // that ends its cycle. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            sb.check_result(o_result);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap(bit allow_idle);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!allow_idle || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Small values make equal maxima common; the extremes show up regularly.
    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_opcode pick_opcode(int unsigned push_weight);
        if ($urandom_range(0, 99) < push_weight) begin
            return OP_PUSH;
        end
        case ($urandom_range(0, 3))
            0:       return OP_POP;
            1:       return OP_READ_TOP;
            2:       return OP_READ_MAX;
            default: return OP_POP_MAX;
        endcase
    endfunction

    // Drives one command beat. Start is lowered only when a gap is asked for,
    // so a back-to-back beat keeps start high without a second assignment in
    // the same step. The beat counts as accepted at the first edge with busy low.
    task automatic send_cmd(input t_opcode op, input logic signed [31:0] value,
                            input int unsigned gap);
        t_cmd_beat cmd;
        cmd.opcode     = op;
        cmd.push_value = value;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_cmd(cmd);
        sent_cmds++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        sent_cmds = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every read or pop on the empty stack after reset reports empty.
        send_cmd(OP_POP,      32'sd0, 0);
        send_cmd(OP_READ_TOP, 32'sd0, 1);
        send_cmd(OP_READ_MAX, 32'sd0, 0);
        send_cmd(OP_POP_MAX,  WORD_MAX, 2);

        // Fill the stack with extremes and alternating bit patterns. The
        // largest value appears twice, so the topmost copy must go first.
        send_cmd(OP_PUSH, 32'sd0,          0);
        send_cmd(OP_PUSH, WORD_MIN,        0);
        send_cmd(OP_PUSH, WORD_MAX,        1);
        send_cmd(OP_PUSH, -32'sd1,         0);
        send_cmd(OP_PUSH, 32'sd1,          0);
        send_cmd(OP_PUSH, 32'sh5555_5555,  0);
        send_cmd(OP_PUSH, 32'shAAAA_AAAA,  3);
        send_cmd(OP_PUSH, WORD_MAX,        0);
        send_cmd(OP_PUSH, 32'sd100,        0);
        send_cmd(OP_PUSH, -32'sd100,       0);
        send_cmd(OP_PUSH, 32'sh0000_FFFF,  0);
        send_cmd(OP_PUSH, 32'shFFFF_0000,  0);
        send_cmd(OP_PUSH, 32'sh7FFF_FFFE,  1);
        send_cmd(OP_PUSH, WORD_MIN,        0);
        send_cmd(OP_PUSH, 32'sd42,         0);
        send_cmd(OP_PUSH, -32'sd42,        0);

        // The stack is full now: this push must be refused.
        send_cmd(OP_PUSH, 32'sd7, 0);

        send_cmd(OP_READ_TOP, 32'sd0, 0);
        send_cmd(OP_READ_MAX, 32'sd0, 0);
        // Two pops of the maximum: the upper copy first, then the lower one,
        // each one shifting everything above it down by one place.
        send_cmd(OP_POP_MAX,  32'sd0, 0);
        send_cmd(OP_POP_MAX,  32'sd0, 0);
        send_cmd(OP_POP,      32'sd0, 4);

        // Random part, in phases. Push-heavy phases drive the stack to full,
        // pop-heavy ones drain it to empty, balanced ones hover in between.
        // Some phases run with no idle cycles at all.
        while (sent_cmds < RANDOM_CMDS) begin
            phase_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len) begin
                if (sent_cmds < RANDOM_CMDS) begin
                    send_cmd(pick_opcode(push_pct), pick_value(), pick_gap(idle_on));
                end
            end
        end
        start <= 1'b0;

        // Wait for every outstanding result, then keep the clock running so that a
        // stray extra beat would still be caught.
        drain_wait = 0;
        while (sb.pending() != 0 && drain_wait < 1000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (40) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Sent %0d commands and checked %0d result beats.",
                 sent_cmds, sb.checked);
        $display("Seen: %0d pushes on a full stack, %0d requests on an empty one, %0d %s",
                 sb.full_hits, sb.empty_hits, sb.deepest_max_pop,
                 "entries shifted at most by one pop of the maximum.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
